[hdl/msfsm_pkg.sv]
package msfsm_pkg;

  localparam int FAULT_W = 16;
  localparam int WAIT_W  = 16;
  localparam int TICK_W  = 17;

  localparam logic [WAIT_W-1:0] INIT_WAIT_RESET = 16'd1000;

  // Fault flag bit positions
  localparam int FLAG_SENSOR   = 0;
  localparam int FLAG_INIT     = 1;
  localparam int FLAG_OVERHEAT = 2;

  // Event kinds
  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_FAULT    = 3'd1;
  localparam logic [2:0] MODE_PHASE    = 3'd2;
  localparam logic [2:0] MODE_DIR      = 3'd3;
  localparam logic [2:0] MODE_FEEDBACK = 3'd4;
  localparam logic [2:0] MODE_OPEN_REQ = 3'd5;
  localparam logic [2:0] MODE_CAL_REQ  = 3'd6;

  // Phase drive codes
  localparam logic [1:0] DRV_Z   = 2'd0;
  localparam logic [1:0] DRV_V0  = 2'd1;
  localparam logic [1:0] DRV_PWM = 2'd2;

  // Direction codes
  localparam logic [1:0] DIR_NULL = 2'd0;

  typedef enum logic [2:0] {
    ST_INIT         = 3'd0,
    ST_DISABLED     = 3'd1,
    ST_PASSIVE      = 3'd2,
    ST_RUN          = 3'd3,
    ST_INTERVENTION = 3'd4,
    ST_OPEN_LOOP    = 3'd5,
    ST_CALIBRATION  = 3'd6,
    ST_FAULT        = 3'd7
  } state_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [3:0]         value;
    logic [FAULT_W-1:0] fault_set;
    logic [FAULT_W-1:0] fault_clear;
    logic               speed_zero;
    logic               freewheel_range;
    logic               feedback_ok;
    logic               phase_cal_ok;
    logic               config_ok;
    logic               sensor_cal_ok;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         cur_state;
    logic [1:0]         phase_drive;
    logic [1:0]         dir_now;
    logic [3:0]         fb_mode_now;
    logic [FAULT_W-1:0] faults_now;
    logic               changed;
  } out_item_t;

endpackage

[hdl/msfsm_in_reg.sv]
module msfsm_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  msfsm_pkg::in_item_t in_data,
  input  logic                advance,
  output logic                q_valid,
  output msfsm_pkg::in_item_t q_data
);

  logic                q_valid_r;
  logic                q_valid_nxt;
  msfsm_pkg::in_item_t q_data_r;

  // Take a new transaction when empty or when the held one moves on.
  assign in_ready = !q_valid_r || advance;

  always_comb begin
    q_valid_nxt = q_valid_r;
    if (in_ready) begin
      q_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else begin
      q_valid_r <= q_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_data_r <= in_data;
    end
  end

  assign q_valid = q_valid_r;
  assign q_data  = q_data_r;

endmodule

[hdl/msfsm_core.sv]
module msfsm_core #(
  parameter int FAULT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [msfsm_pkg::WAIT_W-1:0]     cfg_wait,
  input  logic                             fire,
  input  msfsm_pkg::in_item_t              item,
  output msfsm_pkg::out_item_t             result
);

  localparam logic [msfsm_pkg::FAULT_W-1:0] FAULT_MASK =
    (FAULT_BITS >= msfsm_pkg::FAULT_W) ? {msfsm_pkg::FAULT_W{1'b1}} :
    msfsm_pkg::FAULT_W'((64'd1 << FAULT_BITS) - 64'd1);

  msfsm_pkg::state_t               state_r, state_nxt, target;
  logic                            enter;
  logic [1:0]                      drive_r, drive_nxt;
  logic [1:0]                      dir_r, dir_nxt;
  logic [3:0]                      fb_r, fb_nxt;
  logic [msfsm_pkg::FAULT_W-1:0]   fault_r, fault_nxt, f_tmp;
  logic [msfsm_pkg::TICK_W-1:0]    ticks_r, ticks_nxt, ticks_inc;
  logic [msfsm_pkg::WAIT_W-1:0]    wait_r;
  logic                            init_done;
  logic                            is_tick, is_fault, is_phase, is_dir, is_fb;
  logic                            is_open, is_cal, val_le1, val_le2, val_zero;

  assign is_tick  = item.mode == msfsm_pkg::MODE_TICK;
  assign is_fault = item.mode == msfsm_pkg::MODE_FAULT;
  assign is_phase = item.mode == msfsm_pkg::MODE_PHASE;
  assign is_dir   = item.mode == msfsm_pkg::MODE_DIR;
  assign is_fb    = item.mode == msfsm_pkg::MODE_FEEDBACK;
  assign is_open  = item.mode == msfsm_pkg::MODE_OPEN_REQ;
  assign is_cal   = item.mode == msfsm_pkg::MODE_CAL_REQ;
  assign val_zero = item.value == 4'd0;
  assign val_le1  = item.value inside {[4'd0:4'd1]};
  assign val_le2  = item.value inside {[4'd0:4'd2]};

  // Saturating init counter.
  assign ticks_inc = (&ticks_r) ? ticks_r : ticks_r + msfsm_pkg::TICK_W'(1);
  assign init_done = ticks_inc > {1'b0, wait_r};

  // Fault flag update.
  always_comb begin
    f_tmp     = fault_r;
    fault_nxt = fault_r;
    case (state_r)
      msfsm_pkg::ST_INIT: begin
        if (is_tick && init_done) begin
          if (!item.phase_cal_ok || !item.config_ok) begin
            f_tmp[msfsm_pkg::FLAG_INIT] = 1'b1;
          end
          f_tmp[msfsm_pkg::FLAG_SENSOR]   = !item.sensor_cal_ok;
          f_tmp[msfsm_pkg::FLAG_OVERHEAT] = 1'b0;
          fault_nxt = f_tmp & FAULT_MASK;
        end
      end
      msfsm_pkg::ST_FAULT: begin
        if (is_fault) begin
          f_tmp = fault_r | item.fault_set;
          if (item.fault_clear != '0) begin
            f_tmp = f_tmp & ~item.fault_clear;
            f_tmp[msfsm_pkg::FLAG_OVERHEAT] = 1'b0;
          end
          fault_nxt = f_tmp & FAULT_MASK;
        end
      end
      default: begin
        if (is_fault) begin
          fault_nxt = (fault_r | item.fault_set) & FAULT_MASK;
        end
      end
    endcase
  end

  // Next state.
  always_comb begin
    enter  = 1'b0;
    target = state_r;
    case (state_r)
      msfsm_pkg::ST_INIT: begin
        if (is_tick && init_done) begin
          enter  = 1'b1;
          target = (fault_nxt != '0) ? msfsm_pkg::ST_FAULT : msfsm_pkg::ST_DISABLED;
        end
      end
      msfsm_pkg::ST_DISABLED: begin
        if (is_fault && fault_nxt != '0) begin
          enter = 1'b1; target = msfsm_pkg::ST_FAULT;
        end else if (is_open && item.speed_zero) begin
          enter = 1'b1; target = msfsm_pkg::ST_OPEN_LOOP;
        end else if (is_cal && item.speed_zero) begin
          enter = 1'b1; target = msfsm_pkg::ST_CALIBRATION;
        end
      end
      msfsm_pkg::ST_PASSIVE: begin
        if (is_fault && fault_nxt != '0) begin
          enter = 1'b1; target = msfsm_pkg::ST_FAULT;
        end else if (is_phase && item.value == 4'd2 && dir_r != msfsm_pkg::DIR_NULL &&
                     item.feedback_ok) begin
          enter = 1'b1; target = msfsm_pkg::ST_RUN;
        end else if (is_open && item.speed_zero) begin
          enter = 1'b1; target = msfsm_pkg::ST_OPEN_LOOP;
        end
      end
      msfsm_pkg::ST_RUN: begin
        if (is_fault && fault_nxt != '0) begin
          enter = 1'b1; target = msfsm_pkg::ST_FAULT;
        end else if (is_phase && val_le1) begin
          enter  = 1'b1;
          target = item.freewheel_range ? msfsm_pkg::ST_PASSIVE :
                                          msfsm_pkg::ST_INTERVENTION;
        end
      end
      msfsm_pkg::ST_INTERVENTION: begin
        if (is_fault && fault_nxt != '0) begin
          enter = 1'b1; target = msfsm_pkg::ST_FAULT;
        end else if (is_phase && val_le1 && item.freewheel_range) begin
          enter = 1'b1; target = msfsm_pkg::ST_PASSIVE;
        end else if (is_phase && item.value == 4'd2 && item.feedback_ok) begin
          enter = 1'b1; target = msfsm_pkg::ST_RUN;
        end
      end
      msfsm_pkg::ST_OPEN_LOOP: begin
        if (is_fault && fault_nxt != '0) begin
          enter = 1'b1; target = msfsm_pkg::ST_FAULT;
        end else if (is_phase && val_le1) begin
          enter = 1'b1; target = msfsm_pkg::ST_PASSIVE;
        end else if (is_dir && item.speed_zero && val_zero) begin
          enter = 1'b1; target = msfsm_pkg::ST_PASSIVE;
        end else if (is_open) begin
          enter  = 1'b1;
          target = val_zero ? msfsm_pkg::ST_PASSIVE : msfsm_pkg::ST_OPEN_LOOP;
        end
      end
      msfsm_pkg::ST_CALIBRATION: begin
        if (is_fault && fault_nxt != '0) begin
          enter = 1'b1; target = msfsm_pkg::ST_FAULT;
        end else if (is_cal) begin
          enter  = 1'b1;
          target = val_zero ? msfsm_pkg::ST_PASSIVE : msfsm_pkg::ST_CALIBRATION;
        end
      end
      msfsm_pkg::ST_FAULT: begin
        if (is_fault && fault_nxt == '0) begin
          enter = 1'b1; target = msfsm_pkg::ST_DISABLED;
        end else if (is_cal && !fault_r[msfsm_pkg::FLAG_OVERHEAT]) begin
          enter = 1'b1; target = msfsm_pkg::ST_CALIBRATION;
        end
      end
      default: begin
        enter  = 1'b0;
        target = state_r;
      end
    endcase
    state_nxt = enter ? target : state_r;
  end

  // Drive, direction, feedback mode and counter.
  always_comb begin
    drive_nxt = drive_r;
    dir_nxt   = dir_r;
    fb_nxt    = fb_r;
    ticks_nxt = ticks_r;
    case (state_r)
      msfsm_pkg::ST_INIT: begin
        if (is_tick) begin
          ticks_nxt = ticks_inc;
        end
      end
      msfsm_pkg::ST_DISABLED: begin
        if (is_dir && val_le2) dir_nxt = item.value[1:0];
        if (is_fb) fb_nxt = item.value;
      end
      msfsm_pkg::ST_PASSIVE: begin
        if (is_tick && drive_r == msfsm_pkg::DRV_V0 && item.freewheel_range) begin
          drive_nxt = msfsm_pkg::DRV_Z;
        end
        if (is_phase && val_zero && item.freewheel_range) drive_nxt = msfsm_pkg::DRV_Z;
        if (is_phase && item.value == 4'd1) drive_nxt = msfsm_pkg::DRV_V0;
        if (is_dir && item.speed_zero && val_le2) dir_nxt = item.value[1:0];
        if (is_fb) fb_nxt = item.value;
      end
      msfsm_pkg::ST_RUN, msfsm_pkg::ST_INTERVENTION: begin
        if (is_fb) fb_nxt = item.value;
      end
      msfsm_pkg::ST_OPEN_LOOP: begin
        if (is_dir && item.speed_zero && !val_zero && val_le2) dir_nxt = item.value[1:0];
        if (is_fb) fb_nxt = item.value;
      end
      msfsm_pkg::ST_CALIBRATION: begin
        if (is_phase && val_zero) drive_nxt = msfsm_pkg::DRV_Z;
        if (is_phase && !val_zero && val_le2) drive_nxt = msfsm_pkg::DRV_V0;
        if (is_dir && item.speed_zero && val_le2) dir_nxt = item.value[1:0];
      end
      default: begin
        drive_nxt = drive_r;
      end
    endcase

    // Entry actions override the in-state effects.
    if (enter) begin
      case (target)
        msfsm_pkg::ST_INIT:        ticks_nxt = '0;
        msfsm_pkg::ST_DISABLED: begin
          drive_nxt = msfsm_pkg::DRV_Z;
          dir_nxt   = msfsm_pkg::DIR_NULL;
        end
        msfsm_pkg::ST_PASSIVE:     drive_nxt = msfsm_pkg::DRV_Z;
        msfsm_pkg::ST_RUN:         drive_nxt = msfsm_pkg::DRV_PWM;
        msfsm_pkg::ST_OPEN_LOOP:   drive_nxt = msfsm_pkg::DRV_V0;
        msfsm_pkg::ST_CALIBRATION: drive_nxt = msfsm_pkg::DRV_V0;
        msfsm_pkg::ST_FAULT:       drive_nxt = msfsm_pkg::DRV_Z;
        default:                   drive_nxt = drive_nxt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msfsm_pkg::ST_INIT;
      drive_r <= msfsm_pkg::DRV_Z;
      dir_r   <= msfsm_pkg::DIR_NULL;
      fb_r    <= '0;
      fault_r <= '0;
      ticks_r <= '0;
      wait_r  <= msfsm_pkg::INIT_WAIT_RESET;
    end else begin
      if (fire) begin
        state_r <= state_nxt;
        drive_r <= drive_nxt;
        dir_r   <= dir_nxt;
        fb_r    <= fb_nxt;
        fault_r <= fault_nxt;
        ticks_r <= ticks_nxt;
      end
      if (cfg_we) begin
        wait_r <= cfg_wait;
      end
    end
  end

  assign result.cur_state   = state_nxt;
  assign result.phase_drive = drive_nxt;
  assign result.dir_now     = dir_nxt;
  assign result.fb_mode_now = fb_nxt;
  assign result.faults_now  = fault_nxt;
  assign result.changed     = enter;

endmodule

[hdl/msfsm_out_reg.sv]
module msfsm_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  msfsm_pkg::out_item_t d,
  output logic                 out_valid,
  input  logic                 out_ready,
  output msfsm_pkg::out_item_t out_data,
  output logic                 free
);

  logic                 valid_r, valid_nxt;
  msfsm_pkg::out_item_t data_r;

  // Room for a new result when empty or when the held one leaves now.
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= d;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[hdl/motor_supervisor_fsm.sv]
// Channel | Direction | Handshake             | Payload
// in_     | input     | in_valid / in_ready   | in_data  (msfsm_pkg::in_item_t)
// out_    | output    | out_valid / out_ready | out_data (msfsm_pkg::out_item_t)
// cfg_    | input     | cfg_valid / cfg_ready | cfg_data (init wait ticks)
//
// One transaction per clock sustained while out_ready is high; an accepted item is held
// in the input register until there is room, then the result register loads and out_valid rises.
// The input register feeds one level of transition logic that writes the result register.
// rst_n (synchronous, active low) empties both registers, enters init, sets wait to 1000.
// A stalled out_ready holds the result; one more item waits in the input register,
// after which in_ready drops. cfg_ready is always high.
module motor_supervisor_fsm #(
  parameter int FAULT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  msfsm_pkg::in_item_t            in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output msfsm_pkg::out_item_t           out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [msfsm_pkg::WAIT_W-1:0]   cfg_data
);

  logic                 q_valid;
  msfsm_pkg::in_item_t  q_data;
  logic                 out_free;
  logic                 advance;
  msfsm_pkg::out_item_t result;

  // Advance the held event into the result register whenever there is room;
  // the supervisor state commits on the same edge.
  assign advance   = q_valid && out_free;
  assign cfg_ready = 1'b1;

  msfsm_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  msfsm_core #(
    .FAULT_BITS (FAULT_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_wait (cfg_data),
    .fire     (advance),
    .item     (q_data),
    .result   (result)
  );

  msfsm_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .d         (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .free      (out_free)
  );

endmodule

[sim/motor_supervisor_fsm_tb.sv]
module motor_supervisor_fsm_tb;

  localparam int FAULT_BITS  = 16;
  localparam int KEEP_BITS   =
    (FAULT_BITS < msfsm_pkg::FAULT_W) ? FAULT_BITS : msfsm_pkg::FAULT_W;
  localparam logic [msfsm_pkg::FAULT_W-1:0] FLAG_KEEP =
    {msfsm_pkg::FAULT_W{1'b1}} >> (msfsm_pkg::FAULT_W - KEEP_BITS);
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_EVENTS = 650;

  // Event kind with no entry in any state
  localparam logic [2:0] MODE_NONE = 3'd7;
  localparam logic [1:0] DIR_CW    = 2'd1;
  localparam logic [1:0] DIR_CCW   = 2'd2;

  // Sensor condition bits, packed in the order of the tail of in_item_t:
  // speed_zero, freewheel_range, feedback_ok, phase_cal_ok, config_ok, sensor_cal_ok
  localparam logic [5:0] C_NONE = 6'b000000;
  localparam logic [5:0] C_SPD0 = 6'b100000;
  localparam logic [5:0] C_FW   = 6'b010000;
  localparam logic [5:0] C_FBOK = 6'b001000;
  localparam logic [5:0] C_ALL  = 6'b111111;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  msfsm_pkg::in_item_t           in_data;
  logic                          out_valid;
  logic                          out_ready;
  msfsm_pkg::out_item_t          out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [msfsm_pkg::WAIT_W-1:0]  cfg_data;

  // Shadow copy of the supervisor, advanced once per accepted event
  msfsm_pkg::state_t             m_state;
  logic [1:0]                    m_drive;
  logic [1:0]                    m_dir;
  logic [3:0]                    m_fbmode;
  logic [msfsm_pkg::FAULT_W-1:0] m_faults;
  logic [msfsm_pkg::TICK_W-1:0]  m_ticks;
  logic [msfsm_pkg::WAIT_W-1:0]  m_wait;
  logic                          m_entered;

  msfsm_pkg::out_item_t          status_queue[$];
  msfsm_pkg::out_item_t          last_status;
  msfsm_pkg::out_item_t          due;
  int                            mismatches;
  int                            cycle_count;
  bit                            no_gaps;

  motor_supervisor_fsm #(.FAULT_BITS(FAULT_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Bound the run; a hung handshake ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stall the result channel with a chance of about 22 in 100, except in the no-gap stretch
  always @(negedge clk) begin
    out_ready = no_gaps || ($urandom_range(99) >= 22);
  end

  // ---------------------------------------------------------------------------
  // Supervisor shadow
  // ---------------------------------------------------------------------------
  function automatic void clear_supervisor();
    m_state   = msfsm_pkg::ST_INIT;
    m_drive   = msfsm_pkg::DRV_Z;
    m_dir     = msfsm_pkg::DIR_NULL;
    m_fbmode  = '0;
    m_faults  = '0;
    m_ticks   = '0;
    m_wait    = msfsm_pkg::INIT_WAIT_RESET;
    m_entered = 1'b0;
  endfunction

  // Run the entry action of a state
  function automatic void enter_state(msfsm_pkg::state_t s);
    m_state   = s;
    m_entered = 1'b1;
    case (s)
      msfsm_pkg::ST_INIT: m_ticks = '0;
      msfsm_pkg::ST_DISABLED: begin
        m_drive = msfsm_pkg::DRV_Z;
        m_dir   = msfsm_pkg::DIR_NULL;
      end
      msfsm_pkg::ST_PASSIVE, msfsm_pkg::ST_FAULT: m_drive = msfsm_pkg::DRV_Z;
      msfsm_pkg::ST_RUN: m_drive = msfsm_pkg::DRV_PWM;
      msfsm_pkg::ST_OPEN_LOOP, msfsm_pkg::ST_CALIBRATION: m_drive = msfsm_pkg::DRV_V0;
      default: ;
    endcase
  endfunction

  // Fault command outside fault: OR in the set bits, clear is ignored
  function automatic void latch_faults(logic [msfsm_pkg::FAULT_W-1:0] set_bits);
    m_faults = (m_faults | set_bits) & FLAG_KEEP;
    if (m_faults != '0) enter_state(msfsm_pkg::ST_FAULT);
  endfunction

  // Drop out-of-range direction codes
  function automatic void take_direction(logic [3:0] v);
    if (v <= 4'd2) m_dir = v[1:0];
  endfunction

  function automatic msfsm_pkg::out_item_t advance_supervisor(msfsm_pkg::in_item_t e);
    msfsm_pkg::out_item_t          r;
    logic [msfsm_pkg::FAULT_W-1:0] f;
    m_entered = 1'b0;
    case (m_state)
      msfsm_pkg::ST_INIT: begin
        if (e.mode == msfsm_pkg::MODE_TICK) begin
          if (m_ticks != '1) m_ticks = m_ticks + msfsm_pkg::TICK_W'(1);
          if (m_ticks > {1'b0, m_wait}) begin
            f = m_faults;
            if (!e.phase_cal_ok || !e.config_ok) f[msfsm_pkg::FLAG_INIT] = 1'b1;
            f[msfsm_pkg::FLAG_SENSOR]   = !e.sensor_cal_ok;
            f[msfsm_pkg::FLAG_OVERHEAT] = 1'b0;
            m_faults = f & FLAG_KEEP;
            enter_state((m_faults != '0) ? msfsm_pkg::ST_FAULT : msfsm_pkg::ST_DISABLED);
          end
        end
      end
      msfsm_pkg::ST_DISABLED: begin
        case (e.mode)
          msfsm_pkg::MODE_FAULT:    latch_faults(e.fault_set);
          msfsm_pkg::MODE_DIR:      take_direction(e.value);
          msfsm_pkg::MODE_FEEDBACK: m_fbmode = e.value;
          msfsm_pkg::MODE_OPEN_REQ: if (e.speed_zero) enter_state(msfsm_pkg::ST_OPEN_LOOP);
          msfsm_pkg::MODE_CAL_REQ:  if (e.speed_zero) enter_state(msfsm_pkg::ST_CALIBRATION);
          default: ;
        endcase
      end
      msfsm_pkg::ST_PASSIVE: begin
        case (e.mode)
          msfsm_pkg::MODE_TICK: begin
            if (m_drive == msfsm_pkg::DRV_V0 && e.freewheel_range) m_drive = msfsm_pkg::DRV_Z;
          end
          msfsm_pkg::MODE_FAULT: latch_faults(e.fault_set);
          msfsm_pkg::MODE_PHASE: begin
            if (e.value == 4'd0) begin
              if (e.freewheel_range) m_drive = msfsm_pkg::DRV_Z;
            end else if (e.value == 4'd1) begin
              m_drive = msfsm_pkg::DRV_V0;
            end else if (e.value == 4'd2) begin
              if (m_dir != msfsm_pkg::DIR_NULL && e.feedback_ok)
                enter_state(msfsm_pkg::ST_RUN);
            end
          end
          msfsm_pkg::MODE_DIR:      if (e.speed_zero) take_direction(e.value);
          msfsm_pkg::MODE_FEEDBACK: m_fbmode = e.value;
          msfsm_pkg::MODE_OPEN_REQ: if (e.speed_zero) enter_state(msfsm_pkg::ST_OPEN_LOOP);
          default: ;
        endcase
      end
      msfsm_pkg::ST_RUN: begin
        case (e.mode)
          msfsm_pkg::MODE_FAULT: latch_faults(e.fault_set);
          msfsm_pkg::MODE_PHASE: begin
            if (e.value <= 4'd1)
              enter_state(e.freewheel_range ? msfsm_pkg::ST_PASSIVE :
                                              msfsm_pkg::ST_INTERVENTION);
          end
          msfsm_pkg::MODE_FEEDBACK: m_fbmode = e.value;
          default: ;
        endcase
      end
      msfsm_pkg::ST_INTERVENTION: begin
        case (e.mode)
          msfsm_pkg::MODE_FAULT: latch_faults(e.fault_set);
          msfsm_pkg::MODE_PHASE: begin
            if (e.value <= 4'd1) begin
              if (e.freewheel_range) enter_state(msfsm_pkg::ST_PASSIVE);
            end else if (e.value == 4'd2) begin
              if (e.feedback_ok) enter_state(msfsm_pkg::ST_RUN);
            end
          end
          msfsm_pkg::MODE_FEEDBACK: m_fbmode = e.value;
          default: ;
        endcase
      end
      msfsm_pkg::ST_OPEN_LOOP: begin
        case (e.mode)
          msfsm_pkg::MODE_FAULT: latch_faults(e.fault_set);
          msfsm_pkg::MODE_PHASE: if (e.value <= 4'd1) enter_state(msfsm_pkg::ST_PASSIVE);
          msfsm_pkg::MODE_DIR: begin
            if (e.speed_zero) begin
              if (e.value == 4'd0) enter_state(msfsm_pkg::ST_PASSIVE);
              else take_direction(e.value);
            end
          end
          msfsm_pkg::MODE_FEEDBACK: m_fbmode = e.value;
          msfsm_pkg::MODE_OPEN_REQ:
            enter_state((e.value == 4'd0) ? msfsm_pkg::ST_PASSIVE : msfsm_pkg::ST_OPEN_LOOP);
          default: ;
        endcase
      end
      msfsm_pkg::ST_CALIBRATION: begin
        case (e.mode)
          msfsm_pkg::MODE_FAULT: latch_faults(e.fault_set);
          msfsm_pkg::MODE_PHASE: begin
            if (e.value == 4'd0) m_drive = msfsm_pkg::DRV_Z;
            else if (e.value <= 4'd2) m_drive = msfsm_pkg::DRV_V0;
          end
          msfsm_pkg::MODE_DIR: if (e.speed_zero) take_direction(e.value);
          msfsm_pkg::MODE_CAL_REQ:
            enter_state((e.value == 4'd0) ? msfsm_pkg::ST_PASSIVE :
                                            msfsm_pkg::ST_CALIBRATION);
          default: ;
        endcase
      end
      default: begin
        // Fault: clear only on a nonzero clear mask, which also drops overheat
        if (e.mode == msfsm_pkg::MODE_FAULT) begin
          f = m_faults | e.fault_set;
          if (e.fault_clear != '0) begin
            f = f & ~e.fault_clear;
            f[msfsm_pkg::FLAG_OVERHEAT] = 1'b0;
          end
          m_faults = f & FLAG_KEEP;
          if (m_faults == '0) enter_state(msfsm_pkg::ST_DISABLED);
        end else if (e.mode == msfsm_pkg::MODE_CAL_REQ) begin
          if (!m_faults[msfsm_pkg::FLAG_OVERHEAT]) enter_state(msfsm_pkg::ST_CALIBRATION);
        end
      end
    endcase
    r.cur_state   = m_state;
    r.phase_drive = m_drive;
    r.dir_now     = m_dir;
    r.fb_mode_now = m_fbmode;
    r.faults_now  = m_faults;
    r.changed     = m_entered;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Event construction
  // ---------------------------------------------------------------------------
  function automatic msfsm_pkg::in_item_t motor_event(
      logic [2:0] m, logic [3:0] v, logic [5:0] cond,
      logic [msfsm_pkg::FAULT_W-1:0] fs, logic [msfsm_pkg::FAULT_W-1:0] fc);
    return {m, v, fs, fc, cond};
  endfunction

  // Mostly meaningful events for the current state, some pure noise
  function automatic msfsm_pkg::in_item_t random_event();
    msfsm_pkg::in_item_t e;
    int unsigned         pick;
    int unsigned         sub;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    {e.speed_zero, e.freewheel_range, e.feedback_ok,
     e.phase_cal_ok, e.config_ok, e.sensor_cal_ok} =
      6'($urandom_range(63) | $urandom_range(63));
    if (pick < 8) begin
      e.mode        = 3'($urandom_range(7));
      e.value       = 4'($urandom_range(15));
      e.fault_set   = msfsm_pkg::FAULT_W'($urandom_range(65535));
      e.fault_clear = msfsm_pkg::FAULT_W'($urandom_range(65535));
      return e;
    end
    if ($urandom_range(99) < 80) e.value = 4'($urandom_range(2));
    else e.value = 4'($urandom_range(15));
    if (sub < 20) e.fault_clear = '0;
    else if (sub < 60) e.fault_clear = '1;
    else e.fault_clear = msfsm_pkg::FAULT_W'($urandom_range(65535));
    if (m_state == msfsm_pkg::ST_FAULT) begin
      // push toward leaving fault, or toward calibration
      if (pick < 50) e.mode = msfsm_pkg::MODE_FAULT;
      else if (pick < 75) e.mode = msfsm_pkg::MODE_CAL_REQ;
      else e.mode = 3'($urandom_range(7));
      if ($urandom_range(99) < 70) e.fault_set = '0;
      else e.fault_set = msfsm_pkg::FAULT_W'(1 << $urandom_range(2));
    end else begin
      if (pick < 22) e.mode = msfsm_pkg::MODE_TICK;
      else if (pick < 30) e.mode = msfsm_pkg::MODE_FAULT;
      else if (pick < 52) e.mode = msfsm_pkg::MODE_PHASE;
      else if (pick < 63) e.mode = msfsm_pkg::MODE_DIR;
      else if (pick < 71) e.mode = msfsm_pkg::MODE_FEEDBACK;
      else if (pick < 84) e.mode = msfsm_pkg::MODE_OPEN_REQ;
      else if (pick < 97) e.mode = msfsm_pkg::MODE_CAL_REQ;
      else e.mode = MODE_NONE;
      sub = $urandom_range(99);
      if (sub < 45) e.fault_set = '0;
      else if (sub < 85) e.fault_set = msfsm_pkg::FAULT_W'(1 << $urandom_range(2));
      else e.fault_set = msfsm_pkg::FAULT_W'($urandom_range(65535));
    end
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------
  // Present one event, hold it until accepted, then predict its status
  task automatic send_event(input msfsm_pkg::in_item_t e);
    @(negedge clk);
    if (!no_gaps && $urandom_range(99) < 22) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_data  = e;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    last_status = advance_supervisor(e);
    status_queue.push_back(last_status);
  endtask

  // Drop valid and hold until every predicted status has come back
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (status_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the init wait register once the pipeline is empty
  task automatic set_wait_ticks(input logic [msfsm_pkg::WAIT_W-1:0] v);
    wait_results_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    m_wait = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Leave any state but init for disabled via fault and a full clear
  task automatic go_disabled();
    if (m_state != msfsm_pkg::ST_FAULT && m_state != msfsm_pkg::ST_DISABLED)
      send_event(motor_event(msfsm_pkg::MODE_FAULT, 4'd0, C_NONE, 16'h0001, 16'h0000));
    if (m_state == msfsm_pkg::ST_FAULT)
      send_event(motor_event(msfsm_pkg::MODE_FAULT, 4'd0, C_NONE, 16'h0000, 16'hFFFF));
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (status_queue.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected status transaction, expected none, actual %h",
                 $time, out_data);
      end else begin
        due = status_queue.pop_front();
        if (due != out_data) begin
          mismatches++;
          $display("%0t: status mismatch, expected %h, actual %h", $time, due, out_data);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Init ignores all but ticks, honors wait changes, exits one tick past the wait
  task automatic test_init_wait();
    int i;
    for (i = 1; i < 8; i++)
      send_event(motor_event(i[2:0], 4'd1, C_ALL, 16'hFFFF, 16'h0000));
    repeat (3)
      send_event(motor_event(msfsm_pkg::MODE_TICK, 4'd0, C_ALL, 16'h0000, 16'h0000));
    set_wait_ticks(16'hFFFF);
    repeat (3)
      send_event(motor_event(msfsm_pkg::MODE_TICK, 4'd0, C_ALL, 16'h0000, 16'h0000));
    set_wait_ticks(16'd8);
    // exit flags decide fault or disabled; all checks pass at least half the time
    while (m_state == msfsm_pkg::ST_INIT)
      send_event(motor_event(msfsm_pkg::MODE_TICK, 4'd0,
                             $urandom_range(1) ? C_ALL : 6'($urandom_range(63)),
                             16'h0000, 16'h0000));
  endtask

  // Walk disabled, open loop, passive, run and intervention
  task automatic test_state_walk();
    go_disabled();
    send_event(motor_event(msfsm_pkg::MODE_DIR, 4'd15, C_SPD0, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_DIR, DIR_CCW, C_NONE, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_FEEDBACK, 4'd15, C_NONE, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_PHASE, 4'd2, C_ALL, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_OPEN_REQ, 4'd1, C_NONE, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_OPEN_REQ, 4'd1, C_SPD0, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_DIR, DIR_CW, C_SPD0, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_OPEN_REQ, 4'd3, C_NONE, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_OPEN_REQ, 4'd0, C_NONE, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_PHASE, 4'd1, C_NONE, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_TICK, 4'd0, C_NONE, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_TICK, 4'd0, C_FW, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_PHASE, 4'd2, C_FBOK, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_FEEDBACK, 4'd9, C_NONE, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_PHASE, 4'd0, C_NONE, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_PHASE, 4'd1, C_NONE, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_PHASE, 4'd2, C_FBOK, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_PHASE, 4'd1, C_FW, 16'h0000, 16'h0000));
  endtask

  // Latch every flag, block calibration on overheat, clear out through calibration
  task automatic test_fault_latch();
    send_event(motor_event(msfsm_pkg::MODE_FAULT, 4'd0, C_ALL, 16'hFFFF, 16'hFFFF));
    send_event(motor_event(msfsm_pkg::MODE_CAL_REQ, 4'd1, C_ALL, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_FAULT, 4'd0, C_NONE, 16'h0000, 16'h0001));
    send_event(motor_event(msfsm_pkg::MODE_CAL_REQ, 4'd1, C_NONE, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_PHASE, 4'd0, C_NONE, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_PHASE, 4'd2, C_NONE, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_PHASE, 4'd3, C_NONE, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_CAL_REQ, 4'd5, C_NONE, 16'h0000, 16'h0000));
    send_event(motor_event(msfsm_pkg::MODE_CAL_REQ, 4'd0, C_NONE, 16'h0000, 16'h0000));
    send_event(motor_event(MODE_NONE, 4'd15, C_ALL, 16'hFFFF, 16'hFFFF));
    send_event(motor_event(msfsm_pkg::MODE_FAULT, 4'd0, C_NONE, 16'h0004, 16'h0000));
    go_disabled();
  endtask

  // Random traffic with a drain, a no-gap stretch and two wait rewrites
  task automatic test_random_traffic();
    int n;
    for (n = 0; n < RANDOM_EVENTS; n++) begin
      no_gaps = (n >= 250 && n < 420);
      if (n == 150) wait_results_drained();
      if (n == 450) set_wait_ticks(16'd0);
      if (n == 600) set_wait_ticks(16'($urandom_range(65535)));
      send_event(random_event());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    mismatches  = 0;
    cycle_count = 0;
    no_gaps     = 1'b0;
    last_status = '0;
    clear_supervisor();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_init_wait();
    test_state_walk();
    test_fault_latch();
    test_random_traffic();

    // drain, then leave room for any stray status transaction
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
